FILE: rtl/bqc_pkg.sv
// Shared types and constants of the billboard quad corner generator.
package bqc_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_POSITION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_LOOK_POINT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_UP_VECTOR  = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic [15:0] TEX_ONE  = 16'h8000;
    localparam logic [14:0] UNIT_Q14 = 15'd16384;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic [14:0]        quad_width;
        logic [14:0]        quad_height;
        logic [15:0]        s_start;
        logic [15:0]        t_start;
        logic [15:0]        s_end;
        logic [15:0]        t_end;
    } job_t;

    typedef struct packed {
        logic signed [15:0] corner_x;
        logic signed [15:0] corner_y;
        logic signed [15:0] corner_z;
        logic [15:0]        tex_s;
        logic [15:0]        tex_t;
        logic [1:0]         corner_number;
        logic               last_corner;
    } corner_t;

endpackage

FILE: rtl/bqc_fifo.sv
// Small first-in first-out queue of fixed-width entries.
module bqc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/bqc_front.sv
// Front end: accepts items, appends frames, resolves texture coordinates of draws.
module bqc_front #(
    parameter int MAX_FRAMES = bqc_pkg::MAX_FRAMES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic signed [15:0] center_x,
    input  logic signed [15:0] center_y,
    input  logic signed [15:0] center_z,
    input  logic [14:0]        quad_width,
    input  logic [14:0]        quad_height,
    input  logic [7:0]         frame_index,
    input  logic [15:0]        tex_s_start,
    input  logic [15:0]        tex_t_start,
    input  logic [15:0]        tex_s_end,
    input  logic [15:0]        tex_t_end,
    output logic               job_push,
    input  logic               job_full,
    output bqc_pkg::job_t      job
);
    import bqc_pkg::*;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    logic [63:0]      store [MAX_FRAMES];
    logic [63:0]      rd_reg;
    logic [CNT_W-1:0] loaded_reg;
    logic             pend_reg;
    logic             none_reg;
    job_t             hold_reg;
    logic             accept;
    logic             do_load;
    logic             do_draw;
    logic [CMP_W-1:0] fi_ext;
    logic [CMP_W-1:0] last_ext;
    logic [IDX_W-1:0] rd_idx;

    assign full     = pend_reg && job_full;
    assign job_push = pend_reg && !job_full;
    assign accept   = push && !full;
    assign do_load  = accept && (command == CMD_LOAD) && (loaded_reg < CNT_W'(MAX_FRAMES));
    assign do_draw  = accept && (command == CMD_DRAW);

    // clamp the frame to the last loaded one
    always_comb
    begin
        fi_ext   = CMP_W'(frame_index);
        last_ext = CMP_W'(loaded_reg) - CMP_W'(1);
        if (fi_ext >= CMP_W'(loaded_reg))
        begin
            rd_idx = last_ext[IDX_W-1:0];
        end
        else
        begin
            rd_idx = fi_ext[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            store[loaded_reg[IDX_W-1:0]] <= {tex_t_end, tex_s_end, tex_t_start, tex_s_start};
        end
        if (do_draw)
        begin
            rd_reg <= store[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
            pend_reg   <= 1'b0;
            none_reg   <= 1'b1;
            hold_reg   <= '0;
        end
        else
        begin
            if (do_load)
            begin
                loaded_reg <= loaded_reg + 1'b1;
            end
            if (do_draw)
            begin
                pend_reg             <= 1'b1;
                none_reg             <= (loaded_reg == '0);
                hold_reg.center_x    <= center_x;
                hold_reg.center_y    <= center_y;
                hold_reg.center_z    <= center_z;
                hold_reg.quad_width  <= quad_width;
                hold_reg.quad_height <= quad_height;
                hold_reg.s_start     <= '0;
                hold_reg.t_start     <= '0;
                hold_reg.s_end       <= '0;
                hold_reg.t_end       <= '0;
            end
            else if (job_push)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        job = hold_reg;
        if (none_reg)
        begin
            job.s_start = '0;
            job.t_start = '0;
            job.s_end   = TEX_ONE;
            job.t_end   = TEX_ONE;
        end
        else
        begin
            job.s_start = rd_reg[15:0];
            job.t_start = rd_reg[31:16];
            job.s_end   = rd_reg[47:32];
            job.t_end   = rd_reg[63:48];
        end
    end

endmodule

FILE: rtl/bqc_engine.sv
// Back end: camera registers, axis normalization sequencer and corner emission.
module bqc_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bqc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             job_valid,
    output logic                             job_pop,
    input  bqc_pkg::job_t                    job,
    output logic                             out_push,
    input  logic                             out_full,
    output bqc_pkg::corner_t                 corner
);
    import bqc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_SQRT,
        S_DIV,
        S_CROSS,
        S_SCALE,
        S_EMIT
    } state_t;

    state_t                   state_reg;
    logic [4:0]               step_reg;
    logic [1:0]               idx_reg;
    logic [1:0]               sel_reg;
    logic [CFG_DATA_W-1:0]    cam_reg;
    logic [CFG_DATA_W-1:0]    look_reg;
    logic [CFG_DATA_W-1:0]    up_reg;
    job_t                     job_reg;
    logic signed [31:0]       vec_reg  [3];
    logic signed [15:0]       view_reg [3];
    logic signed [15:0]       hz_reg   [3];
    logic signed [15:0]       vt_reg   [3];
    logic signed [15:0]       h_reg    [3];
    logic signed [15:0]       w_reg    [3];
    logic signed [63:0]       prod_reg;
    logic signed [31:0]       tmp_reg;
    logic [63:0]              acc_reg;
    logic [63:0]              s_reg;
    logic [63:0]              root_reg;
    logic [63:0]              bit_reg;
    logic [31:0]              drem_reg;
    logic [14:0]              dlow_reg;
    logic [14:0]              quo_reg;

    logic signed [15:0]       cam_c  [3];
    logic signed [15:0]       look_c [3];
    logic signed [15:0]       up_c   [3];
    logic signed [31:0]       mul_a;
    logic signed [31:0]       mul_b;
    logic [63:0]              trial;
    logic [31:0]              len;
    logic [32:0]              rem2;
    logic                     rem_ge;
    logic signed [31:0]       div_v;
    logic [31:0]              div_m;
    logic [14:0]              q_clip;
    logic signed [15:0]       q_signed;
    logic [2:0]               prev_k;
    logic signed [31:0]       p32;
    logic [31:0]              p_mag;
    logic [31:0]              p_rnd;
    logic signed [15:0]       scaled;
    logic [1:0]               k;
    logic                     hs;
    logic                     vs;

    function automatic logic signed [15:0] pick16(input logic signed [15:0] v [3],
                                                  input logic [1:0] i);
        case (i)
            2'd0:    return v[0];
            2'd1:    return v[1];
            default: return v[2];
        endcase
    endfunction

    function automatic logic signed [31:0] pick32(input logic signed [31:0] v [3],
                                                  input logic [1:0] i);
        case (i)
            2'd0:    return v[0];
            2'd1:    return v[1];
            default: return v[2];
        endcase
    endfunction

    function automatic logic [1:0] cross_a(input logic [2:0] s);
        case (s)
            3'd0:    return 2'd1;
            3'd1:    return 2'd2;
            3'd2:    return 2'd2;
            3'd3:    return 2'd0;
            3'd4:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    function automatic logic [1:0] cross_b(input logic [2:0] s);
        case (s)
            3'd0:    return 2'd2;
            3'd1:    return 2'd1;
            3'd2:    return 2'd0;
            3'd3:    return 2'd2;
            3'd4:    return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
        if (x > 18'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (x < -18'sd32768)
        begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

    always_comb
    begin
        cam_c[0]  = cam_reg[15:0];
        cam_c[1]  = cam_reg[31:16];
        cam_c[2]  = cam_reg[47:32];
        look_c[0] = look_reg[15:0];
        look_c[1] = look_reg[31:16];
        look_c[2] = look_reg[47:32];
        up_c[0]   = up_reg[15:0];
        up_c[1]   = up_reg[31:16];
        up_c[2]   = up_reg[47:32];
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = pick32(vec_reg, step_reg[1:0]);
                mul_b = pick32(vec_reg, step_reg[1:0]);
            end
            S_CROSS:
            begin
                if (sel_reg == 2'd0)
                begin
                    mul_a = 32'(pick16(up_c, cross_a(step_reg[2:0])));
                end
                else
                begin
                    mul_a = 32'(pick16(hz_reg, cross_a(step_reg[2:0])));
                end
                mul_b = 32'(pick16(view_reg, cross_b(step_reg[2:0])));
            end
            S_SCALE:
            begin
                if (step_reg < 5'd3)
                begin
                    mul_a = 32'(pick16(hz_reg, step_reg[1:0]));
                    mul_b = 32'(signed'({1'b0, job_reg.quad_width}));
                end
                else
                begin
                    mul_a = 32'(pick16(vt_reg, 2'(step_reg - 5'd3)));
                    mul_b = 32'(signed'({1'b0, job_reg.quad_height}));
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // square root, division and rounding datapath
    always_comb
    begin
        trial    = root_reg + bit_reg;
        len      = root_reg[31:0];
        rem2     = {drem_reg, dlow_reg[14]};
        rem_ge   = (rem2 >= {1'b0, len});
        div_v    = pick32(vec_reg, idx_reg);
        div_m    = div_v[31] ? (~div_v + 32'd1) : div_v;
        q_clip   = (len == '0) ? '0 : ((quo_reg > UNIT_Q14) ? UNIT_Q14 : quo_reg);
        q_signed = div_v[31] ? -signed'({1'b0, q_clip}) : signed'({1'b0, q_clip});
        prev_k   = 3'(step_reg - 5'd1);
        p32      = prod_reg[31:0];
        p_mag    = p32[31] ? (~p32 + 32'd1) : p32;
        p_rnd    = p_mag + 32'd16384;
        scaled   = p32[31] ? -signed'(16'(p_rnd >> 15)) : signed'(16'(p_rnd >> 15));
    end

    // corner assembly
    always_comb
    begin
        k  = step_reg[1:0];
        hs = (k == 2'd0) || (k == 2'd3);
        vs = (k == 2'd0) || (k == 2'd1);
        corner.corner_x = sat16(18'(job_reg.center_x)
                                + (hs ? 18'(h_reg[0]) : -18'(h_reg[0]))
                                + (vs ? 18'(w_reg[0]) : -18'(w_reg[0])));
        corner.corner_y = sat16(18'(job_reg.center_y)
                                + (hs ? 18'(h_reg[1]) : -18'(h_reg[1]))
                                + (vs ? 18'(w_reg[1]) : -18'(w_reg[1])));
        corner.corner_z = sat16(18'(job_reg.center_z)
                                + (hs ? 18'(h_reg[2]) : -18'(h_reg[2]))
                                + (vs ? 18'(w_reg[2]) : -18'(w_reg[2])));
        corner.tex_s         = hs ? job_reg.s_start : job_reg.s_end;
        corner.tex_t         = vs ? job_reg.t_end : job_reg.t_start;
        corner.corner_number = k;
        corner.last_corner   = (k == 2'd3);
    end

    assign job_pop  = (state_reg == S_IDLE) && job_valid;
    assign out_push = (state_reg == S_EMIT) && !out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
            sel_reg   <= '0;
            cam_reg   <= '0;
            look_reg  <= '0;
            up_reg    <= '0;
            job_reg   <= '0;
            prod_reg  <= '0;
            tmp_reg   <= '0;
            acc_reg   <= '0;
            s_reg     <= '0;
            root_reg  <= '0;
            bit_reg   <= '0;
            drem_reg  <= '0;
            dlow_reg  <= '0;
            quo_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                vec_reg[i]  <= '0;
                view_reg[i] <= '0;
                hz_reg[i]   <= '0;
                vt_reg[i]   <= '0;
                h_reg[i]    <= '0;
                w_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CAMERA_POSITION:   cam_reg  <= cfg_data;
                    CFG_CAMERA_LOOK_POINT: look_reg <= cfg_data;
                    CFG_CAMERA_UP_VECTOR:  up_reg   <= cfg_data;
                    default:               ;
                endcase
            end

            prod_reg <= mul_a * mul_b;

            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        for (int i = 0; i < 3; i++)
                        begin
                            vec_reg[i] <= 32'(look_c[i]) - 32'(cam_c[i]);
                        end
                        sel_reg   <= '0;
                        step_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_SQ;
                    end
                end

                S_SQ:
                begin
                    if (step_reg != '0)
                    begin
                        acc_reg <= acc_reg + prod_reg;
                    end
                    if (step_reg == 5'd3)
                    begin
                        s_reg     <= acc_reg + prod_reg;
                        root_reg  <= '0;
                        bit_reg   <= 64'd1 << 62;
                        step_reg  <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end

                S_SQRT:
                begin
                    if (s_reg >= trial)
                    begin
                        s_reg    <= s_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd31)
                    begin
                        step_reg  <= '0;
                        idx_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        drem_reg <= {1'b0, div_m[31:1]};
                        dlow_reg <= {div_m[0], 14'd0};
                        quo_reg  <= '0;
                        step_reg <= step_reg + 1'b1;
                    end
                    else if (step_reg != 5'd16)
                    begin
                        dlow_reg <= dlow_reg << 1;
                        if (rem_ge)
                        begin
                            drem_reg <= 32'(rem2 - {1'b0, len});
                            quo_reg  <= {quo_reg[13:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= rem2[31:0];
                            quo_reg  <= {quo_reg[13:0], 1'b0};
                        end
                        step_reg <= step_reg + 1'b1;
                    end
                    else
                    begin
                        case (sel_reg)
                            2'd0:    view_reg[idx_reg] <= q_signed;
                            2'd1:    hz_reg[idx_reg]   <= q_signed;
                            default: vt_reg[idx_reg]   <= q_signed;
                        endcase
                        step_reg <= '0;
                        if (idx_reg == 2'd2)
                        begin
                            state_reg <= (sel_reg == 2'd2) ? S_SCALE : S_CROSS;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end

                S_CROSS:
                begin
                    if (step_reg != '0)
                    begin
                        if (!prev_k[0])
                        begin
                            tmp_reg <= p32;
                        end
                        else
                        begin
                            vec_reg[prev_k[2:1]] <= tmp_reg - p32;
                        end
                    end
                    if (step_reg == 5'd6)
                    begin
                        sel_reg   <= sel_reg + 1'b1;
                        step_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_SQ;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end

                S_SCALE:
                begin
                    if (step_reg != '0)
                    begin
                        if (prev_k < 3'd3)
                        begin
                            h_reg[prev_k[1:0]] <= scaled;
                        end
                        else
                        begin
                            w_reg[2'(prev_k - 3'd3)] <= scaled;
                        end
                    end
                    if (step_reg == 5'd6)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end

                S_EMIT:
                begin
                    if (!out_full)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg[1:0] == 2'd3)
                        begin
                            step_reg  <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/billboard_quad_corners.sv
// Top level of the camera-facing billboard quad generator.
// A load transaction appends a texture frame while the frame store has room. In the back
// end a draw transaction takes the job, then runs three axis normalizations (squaring, a
// 32-step square root and three divisions, each a load, 15 quotient steps and a write,
// all on one shared unit), plus two cross products and the scaling, and then emits the
// four corners, holding while the result side is full. Draws queue up in front, so loads
// and further draws are taken while a quad is still being worked on.
module billboard_quad_corners #(
    parameter int MAX_FRAMES = bqc_pkg::MAX_FRAMES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bqc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bqc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic                           command,
    input  logic signed [15:0]             center_x,
    input  logic signed [15:0]             center_y,
    input  logic signed [15:0]             center_z,
    input  logic [14:0]                    quad_width,
    input  logic [14:0]                    quad_height,
    input  logic [7:0]                     frame_index,
    input  logic [15:0]                    tex_s_start,
    input  logic [15:0]                    tex_t_start,
    input  logic [15:0]                    tex_s_end,
    input  logic [15:0]                    tex_t_end,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [15:0]             corner_x,
    output logic signed [15:0]             corner_y,
    output logic signed [15:0]             corner_z,
    output logic [15:0]                    tex_s,
    output logic [15:0]                    tex_t,
    output logic [1:0]                     corner_number,
    output logic                           last_corner
);
    import bqc_pkg::*;

    job_t    front_job;
    job_t    back_job;
    corner_t eng_corner;
    corner_t out_corner;
    logic    job_push;
    logic    job_full;
    logic    job_empty;
    logic    job_pop;
    logic    out_push;
    logic    out_full;

    bqc_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .quad_width  (quad_width),
        .quad_height (quad_height),
        .frame_index (frame_index),
        .tex_s_start (tex_s_start),
        .tex_t_start (tex_t_start),
        .tex_s_end   (tex_s_end),
        .tex_t_end   (tex_t_end),
        .job_push    (job_push),
        .job_full    (job_full),
        .job         (front_job)
    );

    bqc_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (2)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .full  (job_full),
        .din   (front_job),
        .pop   (job_pop),
        .empty (job_empty),
        .dout  (back_job)
    );

    bqc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (!job_empty),
        .job_pop   (job_pop),
        .job       (back_job),
        .out_push  (out_push),
        .out_full  (out_full),
        .corner    (eng_corner)
    );

    bqc_fifo #(
        .WIDTH ($bits(corner_t)),
        .DEPTH (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .full  (out_full),
        .din   (eng_corner),
        .pop   (pop),
        .empty (empty),
        .dout  (out_corner)
    );

    assign corner_x      = out_corner.corner_x;
    assign corner_y      = out_corner.corner_y;
    assign corner_z      = out_corner.corner_z;
    assign tex_s         = out_corner.tex_s;
    assign tex_t         = out_corner.tex_t;
    assign corner_number = out_corner.corner_number;
    assign last_corner   = out_corner.last_corner;

endmodule

FILE: rtl/bqc_checker.sv
// Port-level checks of the billboard quad generator and their binding.
module bqc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic signed [15:0]             corner_x,
    input logic [1:0]                     corner_number,
    input logic                           last_corner
);

    // the last flag marks exactly the fourth corner
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_corner == (corner_number == 2'd3)))
        else $error("last_corner does not match corner_number");

    // corners of one quad follow each other without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_corner) |=> !empty)
        else $error("gap inside a quad");

    // corners of one quad come in order
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_corner) |=>
            (corner_number == 2'($past(corner_number) + 2'd1)))
        else $error("corner out of order");

    // a waiting corner holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(corner_x)))
        else $error("waiting corner changed");

    // nothing to take and room to push right after reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

endmodule

bind billboard_quad_corners bqc_checker u_bqc_checker (.*);
